>>> rtl/core/sdmc_pkg.sv
// ----------------------------------------------------------------------------
// sdmc_pkg
// Shared types, codes, constants and calendar tables of the scheduled door
// motor controller.
// ----------------------------------------------------------------------------
package sdmc_pkg;

	localparam int TABLE_DEPTH = 366;
	localparam int DAY_W       = $clog2(TABLE_DEPTH + 1);
	localparam int RUN_COUNT   = 7;

	localparam logic [5:0]  SEC_MAX   = 6'd59;
	localparam logic [5:0]  MIN_MAX   = 6'd59;
	localparam logic [4:0]  HOUR_MAX  = 5'd23;
	localparam logic [13:0] YEAR_MIN  = 14'd1000;
	localparam logic [12:0] RECIP_100 = 13'd5243;
	localparam int          RECIP_SH  = 19;

	localparam logic [DAY_W-1:0] RUN_END [RUN_COUNT] = '{
		DAY_W'(15), DAY_W'(62), DAY_W'(115), DAY_W'(235),
		DAY_W'(270), DAY_W'(307), DAY_W'(366)
	};
	localparam logic [4:0] RUN_VALUE [RUN_COUNT] = '{
		5'd17, 5'd18, 5'd19, 5'd20, 5'd19, 5'd18, 5'd17
	};

	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_POLL = 2'd1,
		OP_SET  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_OPENING = 2'd1,
		PH_CLOSING = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		CMD_STOP  = 2'd0,
		CMD_OPEN  = 2'd1,
		CMD_CLOSE = 2'd2
	} cmd_t;

	typedef enum logic [3:0] {
		REG_DATE_YEAR  = 4'd0,
		REG_DATE_MONTH = 4'd1,
		REG_DATE_DAY   = 4'd2,
		REG_OPEN_HOUR  = 4'd3
	} reg_idx_t;

	typedef struct packed {
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
	} date_cfg_t;

	typedef struct packed {
		logic [DAY_W-1:0] day_number;
		logic [4:0]       closing_hour;
		logic             date_error;
	} cal_info_t;

	function automatic logic [4:0] month_len(input logic [3:0] m);
		logic [4:0] len;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
			4'd2:                                        len = 5'd28;
			default:                                     len = 5'd0;
		endcase
		return len;
	endfunction

	function automatic logic [8:0] cum_days(input logic [3:0] m);
		logic [8:0] c;
		case (m)
			4'd1:    c = 9'd0;
			4'd2:    c = 9'd31;
			4'd3:    c = 9'd59;
			4'd4:    c = 9'd90;
			4'd5:    c = 9'd120;
			4'd6:    c = 9'd151;
			4'd7:    c = 9'd181;
			4'd8:    c = 9'd212;
			4'd9:    c = 9'd243;
			4'd10:   c = 9'd273;
			4'd11:   c = 9'd304;
			4'd12:   c = 9'd334;
			default: c = 9'd0;
		endcase
		return c;
	endfunction

	function automatic logic [4:0] close_hour_rom(input logic [DAY_W-1:0] idx);
		logic [4:0] val;
		val = RUN_VALUE[RUN_COUNT-1];
		for (int r = RUN_COUNT - 1; r >= 0; r--) begin
			if (idx < RUN_END[r]) begin
				val = RUN_VALUE[r];
			end
		end
		return val;
	endfunction

endpackage

>>> rtl/core/sdmc_item_if.sv
// ----------------------------------------------------------------------------
// sdmc_item_if
// Input item channel: operation code, limit switch levels and time to load.
// ----------------------------------------------------------------------------
interface sdmc_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic       up_level;
	logic       down_level;
	logic [4:0] set_hour;
	logic [5:0] set_minute;
	logic [5:0] set_second;

	modport source (output valid, operation, up_level, down_level,
		set_hour, set_minute, set_second, input ready);
	modport sink (input valid, operation, up_level, down_level,
		set_hour, set_minute, set_second, output ready);
endinterface

>>> rtl/core/sdmc_result_if.sv
// ----------------------------------------------------------------------------
// sdmc_result_if
// Result channel: motor command, door phase, time of day and calendar status.
// ----------------------------------------------------------------------------
interface sdmc_result_if import sdmc_pkg::*; ;
	logic             valid;
	logic             ready;
	logic [1:0]       motor_command;
	logic [1:0]       door_phase;
	logic [4:0]       now_hour;
	logic [5:0]       now_minute;
	logic [5:0]       now_second;
	logic [DAY_W-1:0] day_number;
	logic [4:0]       closing_hour;
	logic             date_error;

	modport source (output valid, motor_command, door_phase, now_hour, now_minute,
		now_second, day_number, closing_hour, date_error, input ready);
	modport sink (input valid, motor_command, door_phase, now_hour, now_minute,
		now_second, day_number, closing_hour, date_error, output ready);
endinterface

>>> rtl/core/sdmc_cfg_if.sv
// ----------------------------------------------------------------------------
// sdmc_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface sdmc_cfg_if;
	logic        valid;
	logic        ready;
	logic [3:0]  addr;
	logic [13:0] data;

	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface

>>> rtl/core/scheduled_door_motor_controller.sv
// ----------------------------------------------------------------------------
// scheduled_door_motor_controller
// Time-of-day clock and door motor sequencer with a calendar-driven closing
// hour.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle unless an unaccepted result holds
// it back, and returns one result per item: each item passes the input register,
// where the tick, set or door rules are applied, and then the result register. The result
// register lets a new item in while the previous result still waits to be
// taken. The date registers feed a registered calendar stage, which is read when
// an item moves from the input register to the result register. The register
// port is always ready.
// ----------------------------------------------------------------------------
module scheduled_door_motor_controller import sdmc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	sdmc_cfg_if.sink      cfg,
	sdmc_item_if.sink     item,
	sdmc_result_if.source result
);

	date_cfg_t  date_q;
	logic [4:0] open_hour_q;
	cal_info_t  cal;

	logic       valid_s1;
	logic [1:0] op_s1;
	logic       up_s1;
	logic       down_s1;
	logic [4:0] set_hour_s1;
	logic [5:0] set_minute_s1;
	logic [5:0] set_second_s1;

	logic [4:0] hour_q, hour_d;
	logic [5:0] min_q, min_d;
	logic [5:0] sec_q, sec_d;
	phase_t     phase_q, phase_d;
	cmd_t       drive_q, drive_d;

	logic       advance;
	logic       res_valid_q;
	logic [1:0] res_cmd_q;
	logic [1:0] res_phase_q;
	logic [4:0] res_hour_q;
	logic [5:0] res_min_q;
	logic [5:0] res_sec_q;
	cal_info_t  res_cal_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			date_q.year  <= 14'd2019;
			date_q.month <= 4'd1;
			date_q.day   <= 5'd1;
			open_hour_q  <= 5'd11;
		end else if (cfg.valid) begin
			case (cfg.addr)
				REG_DATE_YEAR:  date_q.year  <= cfg.data;
				REG_DATE_MONTH: date_q.month <= cfg.data[3:0];
				REG_DATE_DAY:   date_q.day   <= cfg.data[4:0];
				REG_OPEN_HOUR:  open_hour_q  <= cfg.data[4:0];
				default: ;
			endcase
		end
	end

	sdmc_calendar u_calendar (
		.clk  (clk),
		.date (date_q),
		.info (cal)
	);

	assign advance    = valid_s1 && (!res_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			op_s1         <= item.operation;
			up_s1         <= item.up_level;
			down_s1       <= item.down_level;
			set_hour_s1   <= item.set_hour;
			set_minute_s1 <= item.set_minute;
			set_second_s1 <= item.set_second;
		end
	end

	always_comb begin
		hour_d  = hour_q;
		min_d   = min_q;
		sec_d   = sec_q;
		phase_d = phase_q;
		drive_d = drive_q;
		case (op_s1)
			OP_TICK: begin
				if (sec_q >= SEC_MAX) begin
					sec_d = 6'd0;
					if (min_q >= MIN_MAX) begin
						min_d = 6'd0;
						hour_d = (hour_q >= HOUR_MAX) ? 5'd0 : hour_q + 5'd1;
					end else begin
						min_d = min_q + 6'd1;
					end
				end else begin
					sec_d = sec_q + 6'd1;
				end
			end
			OP_SET: begin
				hour_d = set_hour_s1;
				min_d  = set_minute_s1;
				sec_d  = set_second_s1;
			end
			OP_POLL: begin
				if (cal.date_error) begin
					drive_d = CMD_STOP;
					phase_d = PH_IDLE;
				end else if ((phase_q == PH_OPENING) && down_s1) begin
					drive_d = CMD_OPEN;
				end else if ((phase_q == PH_CLOSING) && up_s1) begin
					drive_d = CMD_CLOSE;
				end else if ((hour_q >= open_hour_q) && (hour_q < cal.closing_hour)
					&& down_s1 && !up_s1) begin
					drive_d = CMD_OPEN;
					phase_d = PH_OPENING;
				end else if ((hour_q >= cal.closing_hour) && up_s1 && !down_s1) begin
					drive_d = CMD_CLOSE;
					phase_d = PH_CLOSING;
				end else begin
					drive_d = CMD_STOP;
					phase_d = PH_IDLE;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hour_q  <= 5'd0;
			min_q   <= 6'd0;
			sec_q   <= 6'd0;
			phase_q <= PH_IDLE;
			drive_q <= CMD_STOP;
		end else if (advance) begin
			hour_q  <= hour_d;
			min_q   <= min_d;
			sec_q   <= sec_d;
			phase_q <= phase_d;
			drive_q <= drive_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_cmd_q   <= drive_d;
			res_phase_q <= phase_d;
			res_hour_q  <= hour_d;
			res_min_q   <= min_d;
			res_sec_q   <= sec_d;
			res_cal_q   <= cal;
		end
	end

	always_comb begin
		result.valid         = res_valid_q;
		result.motor_command = res_cmd_q;
		result.door_phase    = res_phase_q;
		result.now_hour      = res_hour_q;
		result.now_minute    = res_min_q;
		result.now_second    = res_sec_q;
		result.day_number    = res_cal_q.day_number;
		result.closing_hour  = res_cal_q.closing_hour;
		result.date_error    = res_cal_q.date_error;
	end

endmodule

>>> rtl/core/sdmc_calendar.sv
// ----------------------------------------------------------------------------
// sdmc_calendar
// Derives the day of year, the date check and the day's closing hour from the
// configured date, registered once per cycle.
// ----------------------------------------------------------------------------
module sdmc_calendar import sdmc_pkg::*; (
	input  logic      clk,
	input  date_cfg_t date,
	output cal_info_t info
);

	logic [26:0]      prod;
	logic [7:0]       cent;
	logic [14:0]      cent_x100;
	logic [14:0]      rem_full;
	logic [6:0]       rem;
	logic             leap;
	logic [4:0]       mlen;
	logic             valid;
	logic [DAY_W-1:0] doy;
	logic [DAY_W-1:0] idx;
	cal_info_t        info_d;
	cal_info_t        info_q;

	always_comb begin
		// The year is split as year = 100 * cent + rem by a reciprocal multiply.
		prod      = 27'(date.year) * 27'(RECIP_100);
		cent      = prod[RECIP_SH +: 8];
		cent_x100 = 15'({cent, 6'b0}) + 15'({cent, 5'b0}) + 15'({cent, 2'b0});
		rem_full  = 15'(date.year) - cent_x100;
		rem       = rem_full[6:0];
		leap      = (date.year[1:0] == 2'b00) && ((rem != 7'd0) || (cent[1:0] == 2'b00));

		mlen = month_len(date.month);
		if (leap && (date.month == 4'd2)) begin
			mlen = 5'd29;
		end

		valid = (date.year >= YEAR_MIN) && (date.month >= 4'd1) && (date.month <= 4'd12)
			&& (date.day != 5'd0) && (date.day <= mlen);

		doy = DAY_W'(cum_days(date.month)) + DAY_W'(date.day)
			+ DAY_W'(leap && (date.month > 4'd2));

		idx = doy - DAY_W'(1);
		if (idx >= DAY_W'(TABLE_DEPTH)) begin
			idx = DAY_W'(TABLE_DEPTH - 1);
		end

		info_d.date_error   = !valid;
		info_d.day_number   = valid ? doy : '0;
		info_d.closing_hour = valid ? close_hour_rom(idx) + 5'd1 : 5'd0;
	end

	always_ff @(posedge clk) begin
		info_q <= info_d;
	end

	assign info = info_q;

endmodule

>>> tb/sdmc_tb_pkg.sv
// ----------------------------------------------------------------------------
// sdmc_tb_pkg
// Scoreboard for the door controller testbench. It keeps its own time of day,
// door phase, motor command and date registers, works out the status that
// each input transfer must return, and checks returned results in order.
// ----------------------------------------------------------------------------
package sdmc_tb_pkg;
	import sdmc_pkg::*;

	localparam logic [1:0] OP_UNUSED  = 2'd3;
	localparam logic [3:0] REG_UNUSED = 4'd9;

	localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
	localparam int unsigned SHUT_RUN_DAYS [7] = '{15, 47, 53, 120, 35, 37, 59};
	localparam int unsigned SHUT_RUN_HOUR [7] = '{17, 18, 19, 20, 19, 18, 17};

	typedef struct packed {
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  open_hour;
	} date_setting_t;

	typedef struct packed {
		logic [1:0]       motor_command;
		logic [1:0]       door_phase;
		logic [4:0]       now_hour;
		logic [5:0]       now_minute;
		logic [5:0]       now_second;
		logic [DAY_W-1:0] day_number;
		logic [4:0]       closing_hour;
		logic             date_error;
	} door_status_t;

	class door_clock_scoreboard;
		logic [13:0]  year;
		logic [3:0]   month;
		logic [4:0]   day;
		logic [4:0]   open_hour;
		logic [5:0]   second_now;
		logic [5:0]   minute_now;
		logic [4:0]   hour_now;
		phase_t       phase;
		cmd_t         drive;
		door_status_t expected_status [$];
		int unsigned  failures;

		function new();
			year       = 14'd2019;
			month      = 4'd1;
			day        = 5'd1;
			open_hour  = 5'd11;
			second_now = '0;
			minute_now = '0;
			hour_now   = '0;
			phase      = PH_IDLE;
			drive      = CMD_STOP;
			failures   = 0;
		endfunction

		function void write_reg(logic [3:0] index, logic [13:0] value);
			case (index)
				REG_DATE_YEAR:  year = value;
				REG_DATE_MONTH: month = value[3:0];
				REG_DATE_DAY:   day = value[4:0];
				REG_OPEN_HOUR:  open_hour = value[4:0];
				default: ;
			endcase
		endfunction

		// Day of year from 1, or zero when the configured date does not exist or its year is below YEAR_MIN.
		function int unsigned day_of_year();
			int unsigned total;
			int unsigned month_end;
			bit          leap;
			if (year < YEAR_MIN || month < 1 || month > 12 || day < 1) begin
				return 0;
			end
			leap = (year % 4 == 0 && year % 100 != 0) || year % 400 == 0;
			month_end = MONTH_DAYS[month - 1] + ((month == 2 && leap) ? 1 : 0);
			if (day > month_end) begin
				return 0;
			end
			total = 32'(day);
			for (int m = 1; m < month; m++) begin
				total += MONTH_DAYS[m - 1] + ((m == 2 && leap) ? 1 : 0);
			end
			return total;
		endfunction

		function int unsigned table_hour(int unsigned index);
			int unsigned run_stop;
			run_stop = 0;
			if (index >= TABLE_DEPTH) begin
				index = TABLE_DEPTH - 1;
			end
			for (int r = 0; r < 7; r++) begin
				run_stop += SHUT_RUN_DAYS[r];
				if (index < run_stop) begin
					return SHUT_RUN_HOUR[r];
				end
			end
			return SHUT_RUN_HOUR[6];
		endfunction

		function void accept_item(logic [1:0] op, logic up, logic down, logic [4:0] h,
			logic [5:0] m, logic [5:0] s);
			int unsigned  doy;
			int unsigned  shut;
			door_status_t status;
			doy  = day_of_year();
			shut = (doy == 0) ? 0 : table_hour(doy - 1) + 1;
			case (op)
				OP_TICK: begin
					if (second_now >= SEC_MAX) begin
						second_now = '0;
						if (minute_now >= MIN_MAX) begin
							minute_now = '0;
							hour_now = (hour_now >= HOUR_MAX) ? 5'd0 : hour_now + 5'd1;
						end else begin
							minute_now = minute_now + 6'd1;
						end
					end else begin
						second_now = second_now + 6'd1;
					end
				end
				OP_SET: begin
					hour_now   = h;
					minute_now = m;
					second_now = s;
				end
				OP_POLL: begin
					if (doy == 0) begin
						drive = CMD_STOP;
						phase = PH_IDLE;
					end else if (phase == PH_OPENING && down) begin
						drive = CMD_OPEN;
					end else if (phase == PH_CLOSING && up) begin
						drive = CMD_CLOSE;
					end else if (hour_now >= open_hour && hour_now < shut && down && !up) begin
						drive = CMD_OPEN;
						phase = PH_OPENING;
					end else if (hour_now >= shut && up && !down) begin
						drive = CMD_CLOSE;
						phase = PH_CLOSING;
					end else begin
						drive = CMD_STOP;
						phase = PH_IDLE;
					end
				end
				default: ;
			endcase
			status.motor_command = drive;
			status.door_phase    = phase;
			status.now_hour      = hour_now;
			status.now_minute    = minute_now;
			status.now_second    = second_now;
			status.day_number    = doy[DAY_W-1:0];
			status.closing_hour  = shut[4:0];
			status.date_error    = (doy == 0);
			expected_status.push_back(status);
		endfunction

		function void check_field(string name, logic [15:0] want, logic [15:0] seen);
			if (seen !== want) begin
				failures++;
				$display("%0t: %s expected %0d, got %0d", $time, name, want, seen);
			end
		endfunction

		function void match_result(door_status_t seen);
			door_status_t want;
			if (expected_status.size() == 0) begin
				failures++;
				$display("%0t: result with no transfer outstanding, expected nothing, got %h",
					$time, seen);
				return;
			end
			want = expected_status.pop_front();
			check_field("motor_command", 16'(want.motor_command), 16'(seen.motor_command));
			check_field("door_phase", 16'(want.door_phase), 16'(seen.door_phase));
			check_field("now_hour", 16'(want.now_hour), 16'(seen.now_hour));
			check_field("now_minute", 16'(want.now_minute), 16'(seen.now_minute));
			check_field("now_second", 16'(want.now_second), 16'(seen.now_second));
			check_field("day_number", 16'(want.day_number), 16'(seen.day_number));
			check_field("closing_hour", 16'(want.closing_hour), 16'(seen.closing_hour));
			check_field("date_error", 16'(want.date_error), 16'(seen.date_error));
		endfunction
	endclass

endpackage

>>> tb/tb_scheduled_door_motor_controller.sv
// ----------------------------------------------------------------------------
// tb_scheduled_door_motor_controller
// Drives tick, set, poll and unused items through the door controller under
// a series of calendar dates and opening hours, with random gaps on both sides in
// most phases, and checks every result against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module tb_scheduled_door_motor_controller import sdmc_pkg::*, sdmc_tb_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PHASE_COUNT = 16;
	localparam int PHASE_ITEMS = 40;
	localparam int CYCLE_LIMIT = 200000;

	localparam date_setting_t FIXED_DATES [11] = '{
		'{14'd2024, 4'd2,  5'd29, 5'd0},
		'{14'd2023, 4'd2,  5'd29, 5'd5},
		'{14'd2000, 4'd12, 5'd31, 5'd23},
		'{14'd1900, 4'd12, 5'd31, 5'd16},
		'{14'd999,  4'd6,  5'd15, 5'd11},
		'{14'd1000, 4'd4,  5'd31, 5'd11},
		'{14'd9999, 4'd13, 5'd1,  5'd8},
		'{14'd2019, 4'd0,  5'd10, 5'd8},
		'{14'd2021, 4'd15, 5'd0,  5'd12},
		'{14'd2020, 4'd3,  5'd0,  5'd12},
		'{14'd2021, 4'd6,  5'd21, 5'd6}
	};

	logic        clk;
	logic        arst_n;
	int unsigned src_idle_pct = 35;
	int unsigned snk_idle_pct = 61;
	int unsigned cycles = 0;

	sdmc_cfg_if    cfg_ch ();
	sdmc_item_if   item_ch ();
	sdmc_result_if result_ch ();

	door_clock_scoreboard sb = new();

	scheduled_door_motor_controller u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.item   (item_ch),
		.result (result_ch)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			result_ch.ready = arst_n && ($urandom_range(99) >= snk_idle_pct);
		end
	end

	always @(posedge clk) begin
		door_status_t seen;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
		if (arst_n && result_ch.valid && result_ch.ready) begin
			seen.motor_command = result_ch.motor_command;
			seen.door_phase    = result_ch.door_phase;
			seen.now_hour      = result_ch.now_hour;
			seen.now_minute    = result_ch.now_minute;
			seen.now_second    = result_ch.now_second;
			seen.day_number    = result_ch.day_number;
			seen.closing_hour  = result_ch.closing_hour;
			seen.date_error    = result_ch.date_error;
			sb.match_result(seen);
		end
		if (arst_n && item_ch.valid && item_ch.ready) begin
			sb.accept_item(item_ch.operation, item_ch.up_level, item_ch.down_level,
				item_ch.set_hour, item_ch.set_minute, item_ch.set_second);
		end
		if (arst_n && cfg_ch.valid && cfg_ch.ready) begin
			sb.write_reg(cfg_ch.addr, cfg_ch.data);
		end
	end

	task automatic send_item(input logic [1:0] op, input logic up, input logic down,
		input logic [4:0] h, input logic [5:0] m, input logic [5:0] s);
		while ($urandom_range(99) < src_idle_pct) begin
			item_ch.valid = 1'b0;
			@(negedge clk);
		end
		item_ch.valid      = 1'b1;
		item_ch.operation  = op;
		item_ch.up_level   = up;
		item_ch.down_level = down;
		item_ch.set_hour   = h;
		item_ch.set_minute = m;
		item_ch.set_second = s;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_register(input logic [3:0] index, input logic [13:0] value);
		cfg_ch.valid = 1'b1;
		cfg_ch.addr  = index;
		cfg_ch.data  = value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	task automatic wait_drain();
		item_ch.valid = 1'b0;
		while (sb.expected_status.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic logic [5:0] near_wrap();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 40) begin
			return 6'd59;
		end else if (pick < 45) begin
			return 6'($urandom_range(63, 60));
		end
		return 6'($urandom_range(59));
	endfunction

	task automatic send_random_item();
		int unsigned pick;
		logic [1:0]  op;
		logic [4:0]  h;
		pick = $urandom_range(99);
		if (pick < 40) begin
			op = OP_POLL;
		end else if (pick < 72) begin
			op = OP_TICK;
		end else if (pick < 95) begin
			op = OP_SET;
		end else begin
			op = OP_UNUSED;
		end
		h = ($urandom_range(19) == 0) ? 5'($urandom_range(31, 24)) : 5'($urandom_range(23));
		send_item(op, 1'($urandom_range(1)), 1'($urandom_range(1)), h, near_wrap(),
			near_wrap());
	endtask

	initial begin : run
		date_setting_t setting;
		item_ch.valid      = 1'b0;
		item_ch.operation  = OP_TICK;
		item_ch.up_level   = 1'b0;
		item_ch.down_level = 1'b0;
		item_ch.set_hour   = '0;
		item_ch.set_minute = '0;
		item_ch.set_second = '0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.addr        = REG_DATE_YEAR;
		cfg_ch.data        = '0;
		arst_n             = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset date is the first of January, closing hour 18, opening hour 11.
		send_item(OP_UNUSED, 1'b1, 1'b1, 5'd31, 6'd63, 6'd63);
		send_item(OP_POLL, 1'b0, 1'b1, 5'd0, 6'd0, 6'd0);
		send_item(OP_SET, 1'b0, 1'b0, 5'd11, 6'd0, 6'd0);
		send_item(OP_POLL, 1'b0, 1'b1, 5'd0, 6'd0, 6'd0);
		send_item(OP_POLL, 1'b1, 1'b1, 5'd0, 6'd0, 6'd0);
		send_item(OP_POLL, 1'b1, 1'b0, 5'd0, 6'd0, 6'd0);
		send_item(OP_SET, 1'b0, 1'b0, 5'd18, 6'd0, 6'd0);
		send_item(OP_POLL, 1'b1, 1'b0, 5'd0, 6'd0, 6'd0);
		send_item(OP_POLL, 1'b1, 1'b1, 5'd0, 6'd0, 6'd0);
		send_item(OP_POLL, 1'b0, 1'b0, 5'd0, 6'd0, 6'd0);
		send_item(OP_SET, 1'b0, 1'b0, 5'd10, 6'd59, 6'd59);
		send_item(OP_POLL, 1'b0, 1'b1, 5'd0, 6'd0, 6'd0);
		send_item(OP_TICK, 1'b0, 1'b0, 5'd0, 6'd0, 6'd0);
		send_item(OP_POLL, 1'b0, 1'b1, 5'd0, 6'd0, 6'd0);
		send_item(OP_SET, 1'b0, 1'b0, 5'd17, 6'd59, 6'd59);
		send_item(OP_POLL, 1'b1, 1'b0, 5'd0, 6'd0, 6'd0);
		send_item(OP_TICK, 1'b0, 1'b0, 5'd0, 6'd0, 6'd0);
		send_item(OP_POLL, 1'b1, 1'b0, 5'd0, 6'd0, 6'd0);
		send_item(OP_SET, 1'b0, 1'b0, 5'd23, 6'd59, 6'd59);
		send_item(OP_TICK, 1'b0, 1'b0, 5'd0, 6'd0, 6'd0);
		send_item(OP_SET, 1'b0, 1'b0, 5'd31, 6'd63, 6'd63);
		send_item(OP_TICK, 1'b0, 1'b0, 5'd0, 6'd0, 6'd0);
		send_item(OP_SET, 1'b0, 1'b0, 5'd22, 6'd59, 6'd63);
		send_item(OP_TICK, 1'b0, 1'b0, 5'd0, 6'd0, 6'd0);
		send_item(OP_UNUSED, 1'b0, 1'b0, 5'd0, 6'd0, 6'd0);

		for (int p = 0; p < PHASE_COUNT; p++) begin
			case (p * 3 / PHASE_COUNT)
				0: begin
					src_idle_pct = 35;
					snk_idle_pct = 61;
				end
				1: begin
					src_idle_pct = 61;
					snk_idle_pct = 35;
				end
				default: begin
					src_idle_pct = 0;
					snk_idle_pct = 0;
				end
			endcase
			if (p < 11) begin
				setting = FIXED_DATES[p];
			end else begin
				setting.year = ($urandom_range(9) == 0) ? 14'($urandom_range(999))
					: 14'($urandom_range(9999, 1000));
				setting.month = ($urandom_range(9) == 0) ? 4'($urandom_range(15))
					: 4'($urandom_range(12, 1));
				setting.day       = 5'($urandom_range(31, 1));
				setting.open_hour = 5'($urandom_range(23));
			end
			wait_drain();
			write_register(REG_DATE_YEAR, setting.year);
			write_register(REG_DATE_MONTH, 14'(setting.month));
			write_register(REG_DATE_DAY, 14'(setting.day));
			write_register(REG_OPEN_HOUR, 14'(setting.open_hour));
			if (p == 0) begin
				write_register(REG_UNUSED, 14'h3FFF);
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n == PHASE_ITEMS / 2) begin
					wait_drain();
				end
				send_random_item();
			end
		end

		wait_drain();
		repeat (8) @(negedge clk);
		if (sb.failures == 0 && sb.expected_status.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
